// ----- rtl/mrr_pkg.sv -----
package mrr_pkg;

  localparam int CAND_W    = 32;
  localparam int WITNESS_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_REM,
    ST_POW,
    ST_PMUL,
    ST_PSQR,
    ST_SQ,
    ST_XSQR,
    ST_DONE
  } st_t;

endpackage

// ----- rtl/mrr_if.sv -----
interface mrr_in_if
  import mrr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CAND_W-1:0]    candidate;
  logic [WITNESS_W-1:0] witness;
  logic                 last_round;

  modport source (output valid, candidate, witness, last_round, input ready);
  modport sink   (input valid, candidate, witness, last_round, output ready);
endinterface

interface mrr_out_if;
  logic valid;
  logic ready;
  logic probable_prime;
  logic final_res;

  modport source (output valid, probable_prime, final_res, input ready);
  modport sink   (input valid, probable_prime, final_res, output ready);
endinterface

// ----- rtl/miller_rabin_round.sv -----
// One Miller-Rabin round per input transaction on an unsigned candidate, with
// the base taken as witness mod (candidate-1) plus 1. Every input transaction
// yields exactly one result transaction; probable_prime is the AND of this
// candidate's rounds so far and re-arms to 1 after the transaction flagged
// last_round. Candidates below two and even candidates other than two are
// rejected straight from idle, with no arithmetic. Other candidates first
// strip the factors of two from candidate-1, then reduce the base, and then
// run one pass of the shared shift-and-add modular multiplier per multiply
// or square (one multiplier bit per cycle); a round of a full-width candidate
// takes up to about 2*WIDTH such passes. in_ch.ready is high only while the
// block is idle; a finished result waits in an output register.
module miller_rabin_round
  import mrr_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mrr_in_if.sink    in_ch,
  mrr_out_if.source out_ch
);

  localparam int KW = $clog2(WIDTH);

  st_t                  state_r, state_nxt;
  logic [WIDTH-1:0]     p_r, p_nxt;
  logic [WIDTH-1:0]     pm1_r, pm1_nxt;
  logic [WIDTH-1:0]     e_r, e_nxt;
  logic [WIDTH-1:0]     acc_r, acc_nxt;
  logic [WIDTH-1:0]     y_r, y_nxt;
  logic [WITNESS_W-1:0] w_r, w_nxt;
  logic [KW-1:0]        r_r, r_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 last_r, last_nxt;
  logic                 pass_r, pass_nxt;
  logic                 rounds_passed_r, rounds_passed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pp_r, out_pp_nxt;
  logic                 out_final_r, out_final_nxt;

  logic             in_fire;
  logic             out_load;
  logic             verdict;
  logic [WIDTH-1:0] cand_w;
  logic             cand_bad;
  logic             mm_start, mm_done;
  logic [WIDTH-1:0] mm_a, mm_b, mm_res;
  logic             rem_start, rem_done;
  logic [WIDTH-1:0] rem_res;

  if (WIDTH > CAND_W) begin : g_ext
    assign cand_w = {{(WIDTH - CAND_W){1'b0}}, in_ch.candidate};
  end else if (WIDTH == CAND_W) begin : g_same
    assign cand_w = in_ch.candidate;
  end else begin : g_trunc
    assign cand_w = in_ch.candidate[WIDTH-1:0];
  end

  // below two, or even and not two
  assign cand_bad = (cand_w[WIDTH-1:1] == '0) ||
                    (!cand_w[0] && cand_w != WIDTH'(2));

  assign in_fire        = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.probable_prime = out_pp_r;
  assign out_ch.final_res      = out_final_r;
  assign verdict        = rounds_passed_r & pass_r;

  mrr_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .m     (p_r),
    .done  (mm_done),
    .res   (mm_res)
  );

  mrr_rem #(.WIDTH(WIDTH)) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .num   (w_r),
    .m     (pm1_r),
    .done  (rem_done),
    .res   (rem_res)
  );

  always_comb begin
    state_nxt         = state_r;
    p_nxt             = p_r;
    pm1_nxt           = pm1_r;
    e_nxt             = e_r;
    acc_nxt           = acc_r;
    y_nxt             = y_r;
    w_nxt             = w_r;
    r_nxt             = r_r;
    k_nxt             = k_r;
    last_nxt          = last_r;
    pass_nxt          = pass_r;
    rounds_passed_nxt = rounds_passed_r;
    out_pp_nxt        = out_pp_r;
    out_final_nxt     = out_final_r;
    out_load          = 1'b0;
    mm_start          = 1'b0;
    mm_a              = acc_r;
    mm_b              = y_r;
    rem_start         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          p_nxt    = cand_w;
          pm1_nxt  = cand_w - WIDTH'(1);
          e_nxt    = cand_w - WIDTH'(1);
          w_nxt    = in_ch.witness;
          last_nxt = in_ch.last_round;
          r_nxt    = '0;
          pass_nxt = 1'b0;
          state_nxt = cand_bad ? ST_DONE : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        // strip factors of two from candidate-1, leaving the odd part
        if (!e_r[0]) begin
          e_nxt = e_r >> 1;
          r_nxt = r_r + KW'(1);
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        if (rem_done) begin
          y_nxt     = rem_res + WIDTH'(1);
          acc_nxt   = WIDTH'(1);
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (e_r[0]) begin
          mm_start  = 1'b1;
          state_nxt = ST_PMUL;
        end else if (e_r[WIDTH-1:1] != '0) begin
          mm_start  = 1'b1;
          mm_a      = y_r;
          state_nxt = ST_PSQR;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_PMUL: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          e_nxt     = {e_r[WIDTH-1:1], 1'b0};
          state_nxt = ST_POW;
        end
      end
      ST_PSQR: begin
        if (mm_done) begin
          y_nxt     = mm_res;
          e_nxt     = e_r >> 1;
          state_nxt = ST_POW;
        end
      end
      ST_SQ: begin
        if (k_r != r_r && acc_r != WIDTH'(1) && acc_r != pm1_r) begin
          mm_start  = 1'b1;
          mm_b      = acc_r;
          state_nxt = ST_XSQR;
        end else begin
          pass_nxt  = (acc_r == pm1_r) || (k_r == '0);
          state_nxt = ST_DONE;
        end
      end
      ST_XSQR: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          k_nxt     = k_r + KW'(1);
          state_nxt = ST_SQ;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load          = 1'b1;
          out_pp_nxt        = verdict;
          out_final_nxt     = last_r;
          rounds_passed_nxt = last_r ? 1'b1 : verdict;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      rounds_passed_r <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      rounds_passed_r <= rounds_passed_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    pm1_r       <= pm1_nxt;
    e_r         <= e_nxt;
    acc_r       <= acc_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    r_r         <= r_nxt;
    k_r         <= k_nxt;
    last_r      <= last_nxt;
    pass_r      <= pass_nxt;
    out_pp_r    <= out_pp_nxt;
    out_final_r <= out_final_nxt;
  end

  a_mm_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == ST_PMUL || state_r == ST_PSQR || state_r == ST_XSQR))
    else $error("multiplier finished outside a wait state");

  a_sq_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQ |-> k_r <= r_r)
    else $error("squaring count ran past the power of two");

  a_x_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQ |-> acc_r < p_r)
    else $error("residue not reduced below candidate");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> rounds_passed_r)
    else $error("verdict did not re-arm after closing round");

endmodule

// ----- rtl/mrr_rem.sv -----
module mrr_rem
  import mrr_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WITNESS_W-1:0] num,
  input  logic [WIDTH-1:0]     m,
  output logic                 done,
  output logic [WIDTH-1:0]     res
);

  localparam int CW = $clog2(WITNESS_W + 1);

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [WITNESS_W-1:0] num_r;
  logic [WIDTH-1:0]     m_r;
  logic [WIDTH-1:0]     rem_r;
  logic [WIDTH:0]       shifted;
  logic [WIDTH:0]       diff;

  // restoring division, one dividend bit per cycle, msb first
  assign shifted = {rem_r, num_r[WITNESS_W-1]};
  assign diff    = shifted - {1'b0, m_r};
  assign done    = busy_r && (cnt_r == '0);
  assign res     = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(WITNESS_W);
      num_r <= num;
      m_r   <= m;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
      num_r <= num_r << 1;
      rem_r <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/mrr_modmul.sv -----
module mrr_modmul #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] res
);

  logic             busy_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] m_r;

  // x + y mod m, both operands already below m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] md);
    logic [WIDTH:0] sum;
    logic [WIDTH:0] dif;
    sum = {1'b0, x} + {1'b0, y};
    dif = sum - {1'b0, md};
    add_mod = dif[WIDTH] ? sum[WIDTH-1:0] : dif[WIDTH-1:0];
  endfunction

  assign done = busy_r && (b_r == '0);
  assign res  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // shift-and-add over the multiplier bits, lsb first, early exit on zero
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      y_r   <= a;
      b_r   <= b;
      m_r   <= m;
    end else if (busy_r && b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= add_mod(acc_r, y_r, m_r);
      end
      y_r <= add_mod(y_r, y_r, m_r);
      b_r <= b_r >> 1;
    end
  end

endmodule
